>>> sv/sv39w_pkg.sv
// ----------------------------------------------------------------------------
// sv39w_pkg
// Shared types, field widths, codes and entry helpers for the Sv39 walker.
// ----------------------------------------------------------------------------
package sv39w_pkg;

    localparam int PPN_W      = 44;
    localparam int VA_W       = 39;
    localparam int PA_W       = 56;
    localparam int ENTRY_W    = 54;
    localparam int WIDX_W     = 12;
    localparam int VPN_W      = 9;
    localparam int CFG_DATA_W = 44;
    localparam int CFG_IDX_W  = 1;
    localparam int ROOT_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SLOT  = 1'd1;

    // opcodes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // entry flag bit positions
    localparam int FLAG_V = 0;
    localparam int FLAG_R = 1;
    localparam int FLAG_X = 3;
    localparam int FLAG_U = 4;
    localparam int PPN_LSB = 10;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [PPN_W-1:0]   ppn_t;
    typedef logic [PA_W-1:0]    paddr_t;

    function automatic ppn_t entry_ppn(input entry_t e);
        return e[ENTRY_W-1:PPN_LSB];
    endfunction

    function automatic logic entry_rwx(input entry_t e);
        return |e[FLAG_X:FLAG_R];
    endfunction

    // final leaf must be valid, user-accessible and carry some permission
    function automatic logic leaf_ok(input entry_t e);
        return e[FLAG_V] & e[FLAG_U] & entry_rwx(e);
    endfunction

endpackage

>>> sv/sv39_translation_walker_top.sv
// ----------------------------------------------------------------------------
// sv39_translation_walker_top
// Three-level Sv39 page-table walker over an on-chip page-table store.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                payload
//  -------   ---  ---------                -------
//  s_        in   s_valid / s_ready        opcode, va, table word index/value
//  m_        out  m_valid / m_ready        physical address, fault, superpage
//  cfg_      in   cfg_wr_en (no wait)      register index, write data
//
//  after reset the store is cleared one word a cycle, all TABLE_PAGES*512 words,
//  and s_ready stays low until that pass ends (config writes still taken)
//  a write goes from IDLE to DONE, as does a translate that faults early; a
//  full walk goes IDLE, ROOT, MID, LEAF, DONE, set by three dependent store reads
//  one transaction is in flight at a time; a finished result sits in the
//  output register, and the next result waits in the walker if m_ready is low
//
module sv39_translation_walker_top
    import sv39w_pkg::*;
#(
    parameter int TABLE_PAGES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [VA_W-1:0]       s_virtual_address,
    input  logic [WIDX_W-1:0]     s_table_word_index,
    input  logic [ENTRY_W-1:0]    s_table_word_value,

    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PA_W-1:0]       m_physical_address,
    output logic                  m_fault,
    output logic                  m_superpage
);

    // store geometry
    localparam int STORE_WORDS = TABLE_PAGES * 512;
    localparam int RAM_AW      = $clog2(STORE_WORDS);
    localparam int SLOT_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // clearing pass after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a transaction
    localparam logic [2:0] ST_ROOT  = 3'd2;  // root entry on the read port
    localparam logic [2:0] ST_MID   = 3'd3;  // level-1 entry on the read port
    localparam logic [2:0] ST_LEAF  = 3'd4;  // level-0 entry on the read port
    localparam logic [2:0] ST_DONE  = 3'd5;  // result waiting for output slot

    logic [2:0]        state_reg, state_next;
    logic [RAM_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // configuration registers
    ppn_t              base_page_reg;
    logic [ROOT_W-1:0] root_slot_reg;

    // walk context and pending result
    logic [VA_W-1:0]   va_reg, va_next;
    paddr_t            res_pa_reg, res_pa_next;
    logic              res_fault_reg, res_fault_next;
    logic              res_super_reg, res_super_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    paddr_t            m_pa_reg, m_pa_next;
    logic              m_fault_reg, m_fault_next;
    logic              m_super_reg, m_super_next;

    // store ports
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    entry_t            ram_rdata;

    // read address pieces
    logic [SLOT_W-1:0] rd_slot;
    logic [VPN_W-1:0]  rd_vpn;
    logic [31:0]       rd_full;
    logic [31:0]       widx_ext;
    logic [31:0]       root_ext;
    logic              widx_ok;
    logic              root_ok;

    // shared window unit, always fed by the entry on the read port
    logic              win_ok;
    logic [SLOT_W-1:0] win_slot;
    paddr_t            leaf_base;

    sv39w_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (STORE_WORDS),
        .ADDR_W (RAM_AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    sv39w_win_check #(
        .TABLE_PAGES (TABLE_PAGES),
        .SLOT_W      (SLOT_W)
    ) u_win (
        .ppn       (entry_ppn(ram_rdata)),
        .base_page (base_page_reg),
        .in_window (win_ok),
        .slot      (win_slot)
    );

    // write index and root slot range checks
    assign widx_ext = 32'(s_table_word_index);
    assign widx_ok  = widx_ext < 32'(STORE_WORDS);
    assign root_ext = 32'(root_slot_reg);
    assign root_ok  = root_ext < 32'(TABLE_PAGES);

    // store word address is slot*512 + entry index
    assign rd_full   = (32'(rd_slot) << VPN_W) | 32'(rd_vpn);
    assign ram_raddr = rd_full[RAM_AW-1:0];

    // leaf PPN as a page address
    assign leaf_base = {entry_ppn(ram_rdata), 12'd0};

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        va_next        = va_reg;
        res_pa_next    = res_pa_reg;
        res_fault_next = res_fault_reg;
        res_super_next = res_super_reg;
        m_valid_next   = m_valid_reg;
        m_pa_next      = m_pa_reg;
        m_fault_next   = m_fault_reg;
        m_super_next   = m_super_reg;
        ram_we         = 1'b0;
        ram_waddr      = widx_ext[RAM_AW-1:0];
        ram_wdata      = s_table_word_value;
        ram_re         = 1'b0;
        rd_slot        = win_slot;
        rd_vpn         = va_reg[29:21];

        // output slot drains on its handshake
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RAM_AW'(STORE_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rd_slot = root_ext[SLOT_W-1:0];
                rd_vpn  = s_virtual_address[38:30];
                if (s_valid) begin
                    va_next        = s_virtual_address;
                    res_pa_next    = '0;
                    res_super_next = 1'b0;
                    res_fault_next = 1'b0;
                    state_next     = ST_DONE;
                    if (s_opcode == OP_WRITE) begin
                        // out of range writes are dropped
                        ram_we = widx_ok;
                    end else if (s_virtual_address[VA_W-1] || !root_ok) begin
                        res_fault_next = 1'b1;
                    end else begin
                        ram_re     = 1'b1;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                // root entry is always a pointer, whatever its RWX bits
                rd_vpn = va_reg[29:21];
                if (!ram_rdata[FLAG_V] || !win_ok) begin
                    res_fault_next = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_MID;
                end
            end
            ST_MID: begin
                rd_vpn     = va_reg[20:12];
                state_next = ST_DONE;
                if (!ram_rdata[FLAG_V]) begin
                    res_fault_next = 1'b1;
                end else if (entry_rwx(ram_rdata)) begin
                    // 2 MB superpage leaf, sum wraps to the address width
                    if (leaf_ok(ram_rdata)) begin
                        res_pa_next    = leaf_base + PA_W'(va_reg[20:0]);
                        res_super_next = 1'b1;
                    end else begin
                        res_fault_next = 1'b1;
                    end
                end else if (!win_ok) begin
                    res_fault_next = 1'b1;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF: begin
                state_next = ST_DONE;
                if (leaf_ok(ram_rdata)) begin
                    res_pa_next = {entry_ppn(ram_rdata), va_reg[11:0]};
                end else begin
                    res_fault_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pa_next    = res_pa_reg;
                    m_fault_next = res_fault_reg;
                    m_super_next = res_super_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            base_page_reg <= '0;
            root_slot_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_TABLE_BASE: begin
                        base_page_reg <= cfg_wr_data[PPN_W-1:0];
                    end
                    CFG_ROOT_SLOT: begin
                        root_slot_reg <= cfg_wr_data[ROOT_W-1:0];
                    end
                    default: begin
                        base_page_reg <= base_page_reg;
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        va_reg        <= va_next;
        res_pa_reg    <= res_pa_next;
        res_fault_reg <= res_fault_next;
        res_super_reg <= res_super_next;
        m_pa_reg      <= m_pa_next;
        m_fault_reg   <= m_fault_next;
        m_super_reg   <= m_super_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = m_pa_reg;
    assign m_fault            = m_fault_reg;
    assign m_superpage        = m_super_reg;

endmodule

>>> sv/sv39w_ram.sv
// ----------------------------------------------------------------------------
// sv39w_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sv39w_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sv39w_win_check.sv
// ----------------------------------------------------------------------------
// sv39w_win_check
// Table pointer window check: maps a table PPN to a store page slot.
// ----------------------------------------------------------------------------
module sv39w_win_check
    import sv39w_pkg::*;
#(
    parameter int TABLE_PAGES = 8,
    parameter int SLOT_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1
) (
    input  ppn_t              ppn,
    input  ppn_t              base_page,
    output logic              in_window,
    output logic [SLOT_W-1:0] slot
);

    logic [PPN_W:0] diff;

    // borrow out means ppn below base
    assign diff      = {1'b0, ppn} - {1'b0, base_page};
    assign in_window = !diff[PPN_W] && (diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
    assign slot      = diff[SLOT_W-1:0];

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Sv39 translation walker: directed walks, the
// extreme window settings, then random table builds and probes, all checked
// against an in-bench walk predictor, mostly under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb
    import sv39w_pkg::*;
();

    localparam int TABLE_PAGES   = 8;
    localparam int STORE_WORDS   = TABLE_PAGES * 512;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 10;

    // entry flag masks built from the package bit positions
    localparam logic [4:0] F_V = 5'b00001 << FLAG_V;
    localparam logic [4:0] F_R = 5'b00001 << FLAG_R;
    localparam logic [4:0] F_W = 5'b00001 << (FLAG_R + 1);
    localparam logic [4:0] F_X = 5'b00001 << FLAG_X;
    localparam logic [4:0] F_U = 5'b00001 << FLAG_U;

    // one expected walk outcome, with the request kept for messages
    typedef struct packed {
        logic            op;
        logic [VA_W-1:0] va;
        paddr_t          pa;
        logic            fault;
        logic            superpage;
    } walk_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [VA_W-1:0]       s_virtual_address;
    logic [WIDX_W-1:0]     s_table_word_index;
    logic [ENTRY_W-1:0]    s_table_word_value;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PA_W-1:0]       m_physical_address;
    logic                  m_fault;
    logic                  m_superpage;

    // predictor state: shadow of the entry store and both registers
    entry_t     table_mem [STORE_WORDS];
    ppn_t       table_base;
    logic [2:0] root_slot;

    walk_result_t    pending_walks [$];
    logic [VA_W-1:0] mapped_vas [$];

    int items_sent     = 0;
    int mismatch_count = 0;
    int stall_left     = 0;
    bit tx_idle        = 1'b1;
    bit rx_idle        = 1'b1;

    sv39_translation_walker_top #(
        .TABLE_PAGES(TABLE_PAGES)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_index      (cfg_wr_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_virtual_address (s_virtual_address),
        .s_table_word_index(s_table_word_index),
        .s_table_word_value(s_table_word_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_physical_address(m_physical_address),
        .m_fault           (m_fault),
        .m_superpage       (m_superpage)
    );

    // 8 unit clock period
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // entry word with random reserved bits between flags and ppn
    function automatic entry_t mk_entry(input ppn_t ppn, input logic [4:0] flags);
        logic [4:0] rsv;
        rsv = 5'($urandom);
        return {ppn, rsv, flags};
    endfunction

    // valid user leaf with some nonzero permission
    function automatic logic [4:0] leaf_flags();
        logic [4:0] f;
        f = F_V | F_U;
        f[FLAG_X:FLAG_R] = 3'($urandom_range(1, 7));
        return f;
    endfunction

    function automatic logic [WIDX_W-1:0] word_index(input int slot,
                                                     input logic [VPN_W-1:0] vpn);
        return WIDX_W'(slot * 512 + int'(vpn));
    endfunction

    function automatic logic [VA_W-1:0] make_va(input logic [VPN_W-1:0] vpn2,
                                                input logic [VPN_W-1:0] vpn1,
                                                input logic [VPN_W-1:0] vpn0,
                                                input logic [11:0] offset);
        return {vpn2, vpn1, vpn0, offset};
    endfunction

    function automatic entry_t read_table(input int slot, input logic [VPN_W-1:0] vpn);
        return table_mem[(slot * 512 + int'(vpn)) % STORE_WORDS];
    endfunction

    // table pointer to store slot; false when outside the store window
    function automatic bit window_slot(input entry_t e, output int slot);
        ppn_t p;
        ppn_t d;
        p = e[ENTRY_W-1:PPN_LSB];
        slot = 0;
        if (p < table_base) return 1'b0;
        d = p - table_base;
        if (d >= PPN_W'(TABLE_PAGES)) return 1'b0;
        slot = int'(d);
        return 1'b1;
    endfunction

    // expected outcome of one transaction; a write updates the shadow store
    function automatic walk_result_t predict_walk(input logic op,
                                                  input logic [VA_W-1:0] va,
                                                  input logic [WIDX_W-1:0] widx,
                                                  input entry_t wval);
        walk_result_t r;
        entry_t       e;
        paddr_t       offset;
        int           slot;
        logic         is_super;
        r    = '0;
        r.op = op;
        r.va = va;
        if (op == OP_WRITE) begin
            if (int'(widx) < STORE_WORDS) table_mem[widx] = wval;
            return r;
        end
        r.fault = 1'b1;
        if (va[VA_W-1]) return r;
        slot = int'(root_slot);
        if (slot >= TABLE_PAGES) return r;
        // root level: only the valid bit matters, always a pointer
        e = read_table(slot, va[38:30]);
        if (!e[FLAG_V] || !window_slot(e, slot)) return r;
        // level 1: rwx makes it a 2 MB leaf
        e = read_table(slot, va[29:21]);
        if (!e[FLAG_V]) return r;
        is_super = |e[FLAG_X:FLAG_R];
        if (!is_super) begin
            if (!window_slot(e, slot)) return r;
            e = read_table(slot, va[20:12]);
        end
        if (!(e[FLAG_V] && e[FLAG_U] && |e[FLAG_X:FLAG_R])) return r;
        offset      = is_super ? {35'b0, va[20:0]} : {44'b0, va[11:0]};
        r.pa        = {e[ENTRY_W-1:PPN_LSB], 12'h000} + offset;
        r.fault     = 1'b0;
        r.superpage = is_super;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // register write, only issued while no transaction is pending
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        if (idx == CFG_TABLE_BASE) begin
            table_base = data[PPN_W-1:0];
        end else begin
            root_slot = data[ROOT_W-1:0];
        end
    endtask

    // one request transaction; the prediction is made at acceptance
    task automatic send_item(input logic op, input logic [VA_W-1:0] va,
                             input logic [WIDX_W-1:0] widx, input entry_t wval);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid            <= 1'b1;
        s_opcode           <= op;
        s_virtual_address  <= va;
        s_table_word_index <= widx;
        s_table_word_value <= wval;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_walks.push_back(predict_walk(op, va, widx, wval));
        items_sent++;
    endtask

    task automatic write_word(input logic [WIDX_W-1:0] widx, input entry_t value);
        logic [63:0] r;
        r = rand64();
        send_item(OP_WRITE, r[VA_W-1:0], widx, value);
    endtask

    task automatic translate(input logic [VA_W-1:0] va);
        logic [63:0] r;
        r = rand64();
        send_item(OP_TRANSLATE, va, r[WIDX_W-1:0], r[63:10]);
    endtask

    // stop sending, wait out every pending result, then let the walker settle
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_walks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // build a two- or three-level path for a random address, optionally with one
    // damaged entry, then probe it and some neighbors
    task automatic map_and_probe(input bit broken);
        logic [63:0]       r;
        logic [VA_W-1:0]   va;
        logic [VA_W-1:0]   probe_va;
        entry_t            walk_e [3];
        logic [WIDX_W-1:0] walk_idx [3];
        logic [4:0]        root_flags;
        int                s1;
        int                s2;
        int                depth;
        int                victim;
        int                bitpos;
        r  = rand64();
        va = r[VA_W-1:0];
        va[VA_W-1] = 1'b0;
        s1 = $urandom_range(0, TABLE_PAGES - 1);
        s2 = $urandom_range(0, TABLE_PAGES - 1);
        // root entries with rwx set must still act as pointers
        root_flags = F_V;
        if ($urandom_range(0, 7) == 0) root_flags[FLAG_X:FLAG_R] = 3'($urandom);
        walk_idx[0] = word_index(int'(root_slot), va[38:30]);
        walk_e[0]   = mk_entry(table_base + PPN_W'(s1), root_flags);
        walk_idx[1] = word_index(s1, va[29:21]);
        if ($urandom_range(0, 2) == 0) begin
            depth     = 2;
            walk_e[1] = mk_entry(PPN_W'(rand64()), leaf_flags());
        end else begin
            depth       = 3;
            walk_e[1]   = mk_entry(table_base + PPN_W'(s2), F_V);
            walk_idx[2] = word_index(s2, va[20:12]);
            walk_e[2]   = mk_entry(PPN_W'(rand64()), leaf_flags());
        end
        if (broken) begin
            victim = $urandom_range(0, depth - 1);
            if ($urandom_range(0, 1) == 0) begin
                bitpos = $urandom_range(0, 4);
                walk_e[victim][bitpos] = ~walk_e[victim][bitpos];
            end else begin
                walk_e[victim] = ENTRY_W'(rand64());
            end
        end
        for (int k = 0; k < depth; k++) write_word(walk_idx[k], walk_e[k]);
        repeat ($urandom_range(1, 3)) begin
            probe_va = va;
            case ($urandom_range(0, 2))
                1: probe_va[11:0] = 12'($urandom);
                2: probe_va[20:0] = 21'($urandom);
                default: ;
            endcase
            translate(probe_va);
        end
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 64) void'(mapped_vas.pop_front());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // hand-built tables: faults at every level, both leaf sizes, field extremes
    task automatic test_directed_walks();
        ppn_t b;
        b = 44'h987_6543_2100;
        cfg_write(CFG_TABLE_BASE, b);
        cfg_write(CFG_ROOT_SLOT, 44'd2);
        // root entry still cleared
        translate(make_va(9'd0, 9'd0, 9'd0, 12'h000));
        // root slot 2 -> slot 3 -> slot 5
        write_word(word_index(2, 9'd0), mk_entry(b + 44'd3, F_V));
        write_word(word_index(3, 9'd0), mk_entry(b + 44'd5, F_V));
        write_word(word_index(5, 9'd0), mk_entry(44'h123_4567_89AB, F_V | F_U | F_R));
        translate(make_va(9'd0, 9'd0, 9'd0, 12'hABC));
        // address at or above 2^38
        translate(make_va(9'h100, 9'd0, 9'd0, 12'hABC));
        // top legal address, root entry never written
        translate(make_va(9'h0FF, 9'h1FF, 9'h1FF, 12'hFFF));
        // leaf without user bit
        write_word(word_index(5, 9'd1), mk_entry(44'h0FF, F_V | F_R | F_W | F_X));
        translate(make_va(9'd0, 9'd0, 9'd1, 12'h001));
        // user leaf with no permission
        write_word(word_index(5, 9'd2), mk_entry(44'h0FF, F_V | F_U));
        translate(make_va(9'd0, 9'd0, 9'd2, 12'h000));
        // leaf not valid
        write_word(word_index(5, 9'd3), mk_entry(44'h0FF, F_U | F_W | F_X));
        translate(make_va(9'd0, 9'd0, 9'd3, 12'h000));
        // superpage with all-ones ppn, address sum wraps
        write_word(word_index(3, 9'd1), mk_entry('1, F_V | F_U | F_X));
        translate(make_va(9'd0, 9'd1, 9'h1FF, 12'hFFF));
        // superpage without user bit
        write_word(word_index(3, 9'd2), mk_entry(44'h5, F_V | F_W));
        translate(make_va(9'd0, 9'd2, 9'd0, 12'h000));
        // level-1 pointers just below and just past the window
        write_word(word_index(3, 9'd3), mk_entry(b - 44'd1, F_V));
        translate(make_va(9'd0, 9'd3, 9'd0, 12'h000));
        write_word(word_index(3, 9'd4), mk_entry(b + PPN_W'(TABLE_PAGES), F_V));
        translate(make_va(9'd0, 9'd4, 9'd0, 12'h000));
        // root entry carrying rwx is still followed
        write_word(word_index(2, 9'd1), mk_entry(b + 44'd3, F_V | F_R | F_W | F_X | F_U));
        translate(make_va(9'd1, 9'd0, 9'd0, 12'h123));
        // root pointer past the window
        write_word(word_index(2, 9'd2), mk_entry(b + PPN_W'(TABLE_PAGES), F_V));
        translate(make_va(9'd2, 9'd0, 9'd0, 12'h000));
        // last word, all-ones value
        write_word('1, '1);
    endtask

    // window at the top of the ppn space, then at zero, with no idling
    task automatic test_config_extremes();
        drain_results();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        cfg_write(CFG_TABLE_BASE, '1);
        cfg_write(CFG_ROOT_SLOT, 44'd7);
        // every pointer lands on the base page itself
        write_word(word_index(7, 9'd0), mk_entry('1, F_V));
        write_word(word_index(0, 9'd1), mk_entry('1, F_V));
        write_word(word_index(0, 9'd2), mk_entry(44'h0AB_CDEF_0123, F_V | F_U | F_R | F_W));
        translate(make_va(9'd0, 9'd1, 9'd2, 12'h555));
        // ppn zero sits below this window
        write_word(word_index(7, 9'd1), mk_entry(44'd0, F_V));
        translate(make_va(9'd1, 9'd1, 9'd2, 12'h000));
        drain_results();
        cfg_write(CFG_TABLE_BASE, '0);
        cfg_write(CFG_ROOT_SLOT, '0);
        write_word(word_index(0, 9'd0), mk_entry(PPN_W'(TABLE_PAGES - 1), F_V));
        write_word(word_index(7, 9'd0), mk_entry(44'h1234, F_V | F_U | F_R));
        translate(make_va(9'd0, 9'd0, 9'h0AA, 12'h0BB));
        write_word(word_index(0, 9'd1), mk_entry(PPN_W'(TABLE_PAGES), F_V));
        translate(make_va(9'd1, 9'd0, 9'd0, 12'h000));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // phases of random window settings; mostly well-formed paths, plus
    // damaged paths, noise writes and arbitrary addresses
    task automatic test_random_walks();
        logic [63:0]     r;
        logic [63:0]     r2;
        logic [VA_W-1:0] va;
        int              target;
        int              pick;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            r  = rand64();
            r2 = rand64();
            case (ph)
                1: begin
                    cfg_write(CFG_TABLE_BASE, '0);
                    cfg_write(CFG_ROOT_SLOT, '0);
                end
                2: begin
                    cfg_write(CFG_TABLE_BASE, '1);
                    cfg_write(CFG_ROOT_SLOT, 44'd7);
                end
                3: begin
                    // highest base whose window does not wrap
                    cfg_write(CFG_TABLE_BASE,
                              {CFG_DATA_W{1'b1}} - CFG_DATA_W'(TABLE_PAGES - 1));
                    cfg_write(CFG_ROOT_SLOT, r2[CFG_DATA_W-1:0]);
                end
                default: begin
                    cfg_write(CFG_TABLE_BASE, r[CFG_DATA_W-1:0]);
                    cfg_write(CFG_ROOT_SLOT, r2[CFG_DATA_W-1:0]);
                end
            endcase
            mapped_vas.delete();
            tx_idle = 1'($urandom_range(0, 1));
            rx_idle = 1'($urandom_range(0, 1));
            target  = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < target) begin
                // occasional switch between idling and back-to-back stretches
                if ($urandom_range(0, 19) == 0) tx_idle = !tx_idle;
                if ($urandom_range(0, 19) == 0) rx_idle = !rx_idle;
                // sender holds off until the walker has fully drained
                if ($urandom_range(0, 49) == 0) drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    map_and_probe(1'b0);
                end else if (pick < 55) begin
                    map_and_probe(1'b1);
                end else if (pick < 72) begin
                    if (mapped_vas.size() != 0) begin
                        va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
                        va[11:0] = 12'($urandom);
                        translate(va);
                    end
                end else if (pick < 86) begin
                    r = rand64();
                    write_word(r[WIDX_W-1:0], ENTRY_W'(rand64()));
                end else begin
                    r = rand64();
                    translate(r[VA_W-1:0]);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result channel: random backpressure and checking
    // ------------------------------------------------------------------------

    // m_ready drops for a drawn number of cycles after each result
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest pending walk
    always @(posedge aclk) begin : check_results
        walk_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_walks.size() == 0) begin
                report_mismatch($sformatf("result transaction with nothing pending, pa %h",
                                          m_physical_address));
            end else begin
                want = pending_walks.pop_front();
                if (m_physical_address !== want.pa)
                    report_mismatch($sformatf("op %0d va %h: address %h, expected %h",
                                              want.op, want.va, m_physical_address, want.pa));
                if (m_fault !== want.fault)
                    report_mismatch($sformatf("op %0d va %h: fault %b, expected %b",
                                              want.op, want.va, m_fault, want.fault));
                if (m_superpage !== want.superpage)
                    report_mismatch($sformatf("op %0d va %h: superpage %b, expected %b",
                                              want.op, want.va, m_superpage,
                                              want.superpage));
            end
            stall_left = rx_idle ? $urandom_range(0, 9) : 0;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_index       = '0;
        cfg_wr_data        = '0;
        s_valid            = 1'b0;
        s_opcode           = OP_WRITE;
        s_virtual_address  = '0;
        s_table_word_index = '0;
        s_table_word_value = '0;
        // store and registers come out of reset cleared
        for (int i = 0; i < STORE_WORDS; i++) table_mem[i] = '0;
        table_base = '0;
        root_slot  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // the clearing pass after reset holds s_ready low; sends just wait
        test_directed_walks();
        test_config_extremes();
        test_random_walks();
        drain_results();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
sv/sv39w_pkg.sv
sv/sv39w_ram.sv
sv/sv39w_win_check.sv
sv/sv39_translation_walker_top.sv
bench/tb.sv
